// File: sv/palindromic_subsequence_counter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the palindromic subsequence counter
// Shared property wrappers, clocked on the rising edge and held off in reset.
// ----------------------------------------------------------------------------
`ifndef PALINDROMIC_SUBSEQUENCE_COUNTER_ASSERT_SVH
`define PALINDROMIC_SUBSEQUENCE_COUNTER_ASSERT_SVH

// same-cycle implication
`define PSC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PSC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// Constants, token type and modular adder for the palindromic subsequence
// counter.
// ----------------------------------------------------------------------------
`default_nettype none

package psc_pkg;

    // digit alphabet size (2 to 16)
    localparam int ALPHABET = 10;
    // digit index width
    localparam int DIG_W    = (ALPHABET > 2) ? $clog2(ALPHABET) : 1;
    // digit field width on the stream
    localparam int DIGIT_W  = 4;
    // count width
    localparam int CNT_W    = 30;
    // counts are kept modulo this prime
    localparam logic [CNT_W:0] MODULUS = 31'd1000000007;
    // digit limit at field width plus one
    localparam logic [DIGIT_W:0] DIGIT_LIM = (DIGIT_W + 1)'(ALPHABET);

    // one digit moving down the cell chain
    typedef struct packed {
        logic               valid;
        logic [DIGIT_W-1:0] digit;
        logic               last;
        logic [CNT_W-1:0]   contrib;   // completed patterns picked up on the way
    } t_token;

    // (x + y) mod MODULUS, both operands already reduced
    function automatic logic [CNT_W-1:0] mod_add(input logic [CNT_W-1:0] x,
                                                 input logic [CNT_W-1:0] y);
        logic [CNT_W:0] s;
        begin
            s = {1'b0, x} + {1'b0, y};
            if (s >= MODULUS) begin
                s = s - MODULUS;
            end
            return s[CNT_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// File: sv/psc_cell.sv
// ----------------------------------------------------------------------------
// psc_cell
// One row of the counter: all prefix counts that start with digit i_row.
// Updates on the digit at its input and hands the digit to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module psc_cell (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_adv,   // chain moves this cycle
    input  wire logic [psc_pkg::DIG_W-1:0]     i_row,   // first digit of this row
    input  wire psc_pkg::t_token               i_tok,
    output      psc_pkg::t_token               o_tok
);

    localparam int A = psc_pkg::ALPHABET;
    localparam int W = psc_pkg::CNT_W;

    // row state: "a", "a b", "a b x", "a b x b" and the row sum of the last
    logic [W-1:0] r_single, n_single;
    logic [W-1:0] r_pair   [A];
    logic [W-1:0] n_pair   [A];
    logic [W-1:0] r_triple [A];
    logic [W-1:0] n_triple [A];
    logic [W-1:0] r_quad   [A];
    logic [W-1:0] n_quad   [A];
    logic [W-1:0] r_rowsum, n_rowsum;
    psc_pkg::t_token r_tok, n_tok;

    logic                      hit;
    logic [psc_pkg::DIG_W-1:0] d;
    logic [W-1:0]              t_sel;

    assign hit   = i_tok.valid && ({1'b0, i_tok.digit} < psc_pkg::DIGIT_LIM);
    assign d     = i_tok.digit[psc_pkg::DIG_W-1:0];
    assign t_sel = hit ? r_triple[d] : '0;

    // next state of the row
    always_comb begin
        n_single = r_single;
        n_rowsum = r_rowsum;
        for (int b = 0; b < A; b++) begin
            n_pair[b]   = r_pair[b];
            n_triple[b] = r_triple[b];
            n_quad[b]   = r_quad[b];
        end
        if (i_tok.valid && i_tok.last) begin
            // end of string: row returns to zero
            n_single = '0;
            n_rowsum = '0;
            for (int b = 0; b < A; b++) begin
                n_pair[b]   = '0;
                n_triple[b] = '0;
                n_quad[b]   = '0;
            end
        end else if (hit) begin
            for (int b = 0; b < A; b++) begin
                n_triple[b] = psc_pkg::mod_add(r_triple[b], r_pair[b]);
            end
            n_quad[d] = psc_pkg::mod_add(r_quad[d], t_sel);
            n_rowsum  = psc_pkg::mod_add(r_rowsum, t_sel);
            n_pair[d] = psc_pkg::mod_add(r_pair[d], r_single);
            if (d == i_row) begin
                n_single = psc_pkg::mod_add(r_single, W'(1));
            end
        end
    end

    // token to the next cell; this row puts its quad sum in contrib when it matches
    always_comb begin
        n_tok = i_tok;
        if (hit && (d == i_row)) begin
            n_tok.contrib = r_rowsum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_single <= '0;
            r_rowsum <= '0;
            for (int b = 0; b < A; b++) begin
                r_pair[b]   <= '0;
                r_triple[b] <= '0;
                r_quad[b]   <= '0;
            end
            r_tok <= '0;
        end else if (i_adv) begin
            r_single <= n_single;
            r_rowsum <= n_rowsum;
            for (int b = 0; b < A; b++) begin
                r_pair[b]   <= n_pair[b];
                r_triple[b] <= n_triple[b];
                r_quad[b]   <= n_quad[b];
            end
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

// File: sv/psc_out.sv
// ----------------------------------------------------------------------------
// psc_out
// Running total at the end of the cell chain and the result register.
// Also produces the chain advance enable.
// ----------------------------------------------------------------------------
`default_nettype none

`include "palindromic_subsequence_counter_assert.svh"

module psc_out (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire psc_pkg::t_token             i_tok,
    input  wire logic                        i_tready,
    output      logic                        o_adv,
    output      logic                        o_tvalid,
    output      logic [psc_pkg::CNT_W-1:0]   o_count
);

    localparam int W = psc_pkg::CNT_W;

    logic         r_out_valid;
    logic [W-1:0] r_total;
    logic [W-1:0] r_count;
    logic [W-1:0] sum;
    logic         fin;
    logic         total_ok;
    logic         count_ok;
    logic         clear_ok;

    // chain moves whenever the result slot is free or being emptied
    assign o_adv = !r_out_valid || i_tready;
    assign sum   = psc_pkg::mod_add(r_total, i_tok.contrib);
    assign fin   = i_tok.valid && i_tok.last;

    // total and result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_total     <= '0;
        end else if (o_adv) begin
            r_out_valid <= i_tok.valid && i_tok.last;
            if (i_tok.valid) begin
                r_total <= i_tok.last ? '0 : sum;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_adv && i_tok.valid && i_tok.last) begin
            r_count <= sum;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_count  = r_count;

    // checker terms
    assign total_ok = ({1'b0, r_total} < psc_pkg::MODULUS);
    assign count_ok = ({1'b0, r_count} < psc_pkg::MODULUS);
    assign clear_ok = (r_total == '0) && r_out_valid;

    `PSC_ASSERT_IMP(a_total_reduced, i_clk, i_rst_n, 1'b1, total_ok, "total not reduced")
    `PSC_ASSERT_IMP(a_count_reduced, i_clk, i_rst_n, r_out_valid, count_ok, "count not reduced")
    `PSC_ASSERT_NXT(a_last_clears, i_clk, i_rst_n, o_adv && fin, clear_ok, "string not closed")
    `PSC_ASSERT_NXT(a_no_spurious, i_clk, i_rst_n, o_adv && !fin, !r_out_valid, "stray result")

endmodule

`default_nettype wire

// File: sv/palindromic_subsequence_counter.sv
// A result is registered once its last digit's token has passed every row cell register and then the result register.
// Throughput: one digit per cycle; each digit walks one row cell per cycle.
// The whole chain holds only while a result waits and the output is not ready.
// Reset (synchronous, active low) zeroes every row count and the running total; the result payload is not reset.
// A transaction with tlast set gives one result and clears all counts behind it.
// ----------------------------------------------------------------------------
// palindromic_subsequence_counter
// Counts length-five palindromic subsequences (a b c b a) of a digit string,
// modulo 1000000007, with one row cell per leading digit.
// ----------------------------------------------------------------------------
`default_nettype none

module palindromic_subsequence_counter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output      logic        o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [3:0] digit, [7:4] zero
    input  wire logic        i_s_axis_tlast,
    output      logic        o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output      logic [31:0] o_m_axis_tdata    // [29:0] count, [31:30] zero
);

    localparam int A = psc_pkg::ALPHABET;

    psc_pkg::t_token            tok [A+1];
    logic                       adv;
    logic [psc_pkg::CNT_W-1:0]  count;

    // incoming digit enters the chain at cell 0
    assign tok[0] = '{valid:   i_s_axis_tvalid,
                      digit:   i_s_axis_tdata[psc_pkg::DIGIT_W-1:0],
                      last:    i_s_axis_tlast,
                      contrib: '0};

    assign o_s_axis_tready = adv;

    // row cells
    for (genvar k = 0; k < A; k++) begin : g_cell
        psc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_row   (psc_pkg::DIG_W'(k)),
            .i_tok   (tok[k]),
            .o_tok   (tok[k+1])
        );
    end

    // total and result
    psc_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tok    (tok[A]),
        .i_tready (i_m_axis_tready),
        .o_adv    (adv),
        .o_tvalid (o_m_axis_tvalid),
        .o_count  (count)
    );

    assign o_m_axis_tdata = {2'b00, count};

endmodule

`default_nettype wire
